// File: rtl/learned_anchor_interpolation_search_assert.svh
// assertion macros for the anchor interpolation search block
// used by the top level, needs a clk and rst in scope
`ifndef LEARNED_ANCHOR_INTERPOLATION_SEARCH_ASSERT_SVH
`define LEARNED_ANCHOR_INTERPOLATION_SEARCH_ASSERT_SVH

// condition implies property in the same cycle
`define LAIS_AST_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// condition implies property in the next cycle
`define LAIS_AST_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: rtl/lais_pkg.sv
// shared constants and types for the anchor interpolation search block
// no dependencies
`timescale 1ns / 1ps

package lais_pkg;

  localparam int ARRAY_DEPTH_DEF  = 4096;
  localparam int ANCHOR_DEPTH_DEF = 1024;
  localparam int SMALL_LIMIT_DEF  = 32;

  localparam int VALUE_W = 64;
  localparam int POS_W   = 12;
  localparam int COUNT_W = 13;
  localparam int TOL_W   = 12;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic CFG_ELEMENT_COUNT = 1'b0;
  localparam logic CFG_TOLERANCE     = 1'b1;

  localparam logic [TOL_W-1:0] TOL_RESET = 12'd8;

  typedef enum logic [22:0] {
    ST_IDLE     = 23'h000001,
    ST_SCAN_RD  = 23'h000002,
    ST_SCAN_CMP = 23'h000004,
    ST_SEED0    = 23'h000008,
    ST_SEED0W   = 23'h000010,
    ST_SEED1W   = 23'h000020,
    ST_BA_CHECK = 23'h000040,
    ST_BA_CMP   = 23'h000080,
    ST_AL_RD    = 23'h000100,
    ST_AR_RD    = 23'h000200,
    ST_PR_SET   = 23'h000400,
    ST_PRED     = 23'h000800,
    ST_MUL      = 23'h001000,
    ST_DIV      = 23'h002000,
    ST_WIN      = 23'h004000,
    ST_LO_RD    = 23'h008000,
    ST_LO_CMP   = 23'h010000,
    ST_HI_CMP   = 23'h020000,
    ST_BS_CHECK = 23'h040000,
    ST_BS_CMP   = 23'h080000,
    ST_SH_CHECK = 23'h100000,
    ST_SH_WR    = 23'h200000,
    ST_DONE     = 23'h400000
  } lais_state_t;

endpackage

// File: rtl/lais_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lais_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/learned_anchor_interpolation_search.sv
// top level of the anchor interpolation search block
// depends on lais_pkg, lais_ram and the assertion macro header
//
//   channel  signals                                   dir
//   in       in_valid in_ready operation               in
//            element_position value
//   out      out_valid out_ready found position         out
//            anchor_added
//   cfg      cfg_write cfg_index cfg_data              in
//
// a load is written to the element ram without leaving idle; a short array
// scan reads and compares one element at a time. the time of a longer lookup
// is set mostly by the one-bit-per-cycle multiply and divide loop; an insert
// moves anchors one at a time through the single read port of the anchor rams.
// the first longer lookup after a load or reset seeds two anchors from the
// first and last elements. reset is synchronous; a result held by out_ready
// low holds the next lookup at its end, while loads and new items keep being taken until then.
`timescale 1ns / 1ps

module learned_anchor_interpolation_search
  import lais_pkg::*;
#(
  parameter int ARRAY_DEPTH  = ARRAY_DEPTH_DEF,
  parameter int ANCHOR_DEPTH = ANCHOR_DEPTH_DEF,
  parameter int SMALL_LIMIT  = SMALL_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [POS_W-1:0]          element_position,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      found,
  output logic [POS_W-1:0]          position,
  output logic                      anchor_added,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [COUNT_W-1:0]        cfg_data
);

  localparam int AW = $clog2(ARRAY_DEPTH);
  localparam int NW = $clog2(ARRAY_DEPTH + 1);
  localparam int LW = AW + 1;
  localparam int KW = $clog2(ANCHOR_DEPTH);
  localparam int CW = $clog2(ANCHOR_DEPTH + 1);
  localparam int PW = VALUE_W + AW;
  localparam int TW = $clog2(PW);
  localparam int WW = ((AW > TOL_W) ? AW : TOL_W) + 2;

  lais_state_t state;

  logic [COUNT_W-1:0] element_count;
  logic [TOL_W-1:0]   tolerance;
  logic [CW-1:0]      anchor_count;

  logic signed [VALUE_W-1:0] key, lv, rv;
  logic [AW-1:0]  li, ri, pred, bmid, span_sh;
  logic [NW-1:0]  nreg, k;
  logic [TOL_W-1:0] tol;
  logic [KW-1:0]  alo, ahi, amid, j;
  logic [LW-1:0]  lo, hi;
  logic [VALUE_W-1:0] num, den, rem;
  logic [PW-1:0]  prod;
  logic [AW-1:0]  q;
  logic [TW-1:0]  cnt;
  logic r_found, r_added;
  logic [AW-1:0] r_pos;

  // ram ports
  logic               e_we;
  logic [AW-1:0]      e_waddr, e_raddr;
  logic [VALUE_W-1:0] e_rdata;
  logic               a_we;
  logic [KW-1:0]      a_waddr, a_raddr;
  logic [VALUE_W-1:0] av_wdata, av_rdata;
  logic [AW-1:0]      ai_wdata, ai_rdata;

  logic in_fire, load_fire;
  logic [NW-1:0] n_in;
  logic [KW-1:0] apos;
  logic [LW-1:0] bs_mid;
  logic [VALUE_W:0] div_t;
  logic div_bit;
  logic [VALUE_W-1:0] rem_next;
  logic [AW-1:0] q_next;
  logic [PW-1:0] prod_next;
  logic [WW-1:0] pw, tw, liw, riw, lo_t, hi_t, pdist_w;
  logic [AW-1:0] span, pdist;

  function automatic logic [KW-1:0] amid_c(input logic [KW-1:0] l, input logic [KW-1:0] h);
    logic [KW:0] s;
    s = ({1'b0, l} + {1'b0, h}) >> 1;
    return KW'(s);
  endfunction

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (operation == OP_LOAD);
  assign n_in = (32'(element_count) > ARRAY_DEPTH) ? NW'(ARRAY_DEPTH) : NW'(element_count);
  assign apos = KW'(alo + 1'b1);
  assign bs_mid = lo + ((hi - lo) >> 1);
  assign span = ri - li;

  assign div_t    = {rem, prod[PW-1]};
  assign div_bit  = (div_t >= {1'b0, den});
  assign rem_next = div_bit ? VALUE_W'(div_t - {1'b0, den}) : VALUE_W'(div_t);
  assign q_next   = AW'({q, div_bit});
  assign prod_next = PW'({prod, 1'b0}) + (span_sh[AW-1] ? PW'(num) : PW'(0));

  assign pw  = WW'(pred);
  assign tw  = WW'(tol);
  assign liw = WW'(li);
  assign riw = WW'(ri);
  assign pdist = (pred > bmid) ? pred - bmid : bmid - pred;
  assign pdist_w = WW'(pdist);

  always_comb begin
    lo_t = (pw > tw) ? pw - tw : liw;
    if (lo_t < liw) begin
      lo_t = liw;
    end
    hi_t = pw + tw;
    if (hi_t > riw) begin
      hi_t = riw;
    end
  end

  // element ram
  assign e_we    = load_fire && (32'(element_position) < ARRAY_DEPTH);
  assign e_waddr = AW'(element_position);

  always_comb begin
    case (state)
      ST_SCAN_RD:  e_raddr = AW'(k);
      ST_SEED0W:   e_raddr = AW'(nreg - 1'b1);
      ST_LO_RD:    e_raddr = AW'(lo);
      ST_LO_CMP:   e_raddr = AW'(hi);
      ST_BS_CHECK: e_raddr = AW'(bs_mid);
      default:     e_raddr = '0;
    endcase
  end

  // anchor rams
  always_comb begin
    a_we     = 1'b0;
    a_waddr  = '0;
    av_wdata = e_rdata;
    ai_wdata = '0;
    case (state)
      ST_SEED0W: begin
        a_we = 1'b1;
      end
      ST_SEED1W: begin
        a_we     = 1'b1;
        a_waddr  = KW'(1);
        ai_wdata = AW'(nreg - 1'b1);
      end
      ST_SH_CHECK: begin
        a_we     = !(j > apos);
        a_waddr  = j;
        av_wdata = key;
        ai_wdata = bmid;
      end
      ST_SH_WR: begin
        a_we     = 1'b1;
        a_waddr  = j;
        av_wdata = av_rdata;
        ai_wdata = ai_rdata;
      end
      default: begin
        a_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_BA_CHECK: a_raddr = amid_c(alo, ahi);
      ST_AL_RD:    a_raddr = alo;
      ST_AR_RD:    a_raddr = apos;
      ST_SH_CHECK: a_raddr = KW'(j - 1'b1);
      default:     a_raddr = '0;
    endcase
  end

  lais_ram #(.WIDTH(VALUE_W), .DEPTH(ARRAY_DEPTH)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(value),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  lais_ram #(.WIDTH(VALUE_W), .DEPTH(ANCHOR_DEPTH)) u_aval (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(av_wdata),
    .raddr(a_raddr), .rdata(av_rdata)
  );

  lais_ram #(.WIDTH(AW), .DEPTH(ANCHOR_DEPTH)) u_aidx (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(ai_wdata),
    .raddr(a_raddr), .rdata(ai_rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      tolerance     <= TOL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ELEMENT_COUNT: element_count <= cfg_data;
        CFG_TOLERANCE:     tolerance     <= cfg_data[TOL_W-1:0];
        default:           tolerance     <= tolerance;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      anchor_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (load_fire) begin
            anchor_count <= '0;
          end else if (in_fire) begin
            key     <= value;
            nreg    <= n_in;
            tol     <= tolerance;
            r_found <= 1'b0;
            r_added <= 1'b0;
            r_pos   <= '0;
            k       <= '0;
            alo     <= '0;
            ahi     <= KW'(anchor_count - 1'b1);
            if (32'(n_in) < SMALL_LIMIT) begin
              state <= (n_in == '0) ? ST_DONE : ST_SCAN_RD;
            end else if (anchor_count == '0) begin
              state <= ST_SEED0;
            end else begin
              state <= ST_BA_CHECK;
            end
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          if ($signed(e_rdata) == key) begin
            r_found <= 1'b1;
            r_pos   <= AW'(k);
            state   <= ST_DONE;
          end else if ((k + 1'b1) < nreg) begin
            k     <= k + 1'b1;
            state <= ST_SCAN_RD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SEED0: begin
          state <= ST_SEED0W;
        end
        ST_SEED0W: begin
          state <= ST_SEED1W;
        end
        ST_SEED1W: begin
          anchor_count <= CW'(2);
          alo   <= '0;
          ahi   <= KW'(1);
          state <= ST_BA_CHECK;
        end
        ST_BA_CHECK: begin
          if (({1'b0, alo} + 1'b1) < {1'b0, ahi}) begin
            amid  <= amid_c(alo, ahi);
            state <= ST_BA_CMP;
          end else begin
            state <= ST_AL_RD;
          end
        end
        ST_BA_CMP: begin
          if ($signed(av_rdata) <= key) begin
            alo <= amid;
          end else begin
            ahi <= amid;
          end
          state <= ST_BA_CHECK;
        end
        ST_AL_RD: begin
          state <= ST_AR_RD;
        end
        ST_AR_RD: begin
          lv    <= $signed(av_rdata);
          li    <= ai_rdata;
          state <= ST_PR_SET;
        end
        ST_PR_SET: begin
          rv    <= $signed(av_rdata);
          ri    <= ai_rdata;
          state <= ST_PRED;
        end
        ST_PRED: begin
          span_sh <= span;
          prod    <= '0;
          rem     <= '0;
          q       <= '0;
          cnt     <= TW'(AW - 1);
          if ((ri < li) || (rv == lv)) begin
            pred  <= li;
            state <= ST_WIN;
          end else if (rv > lv) begin
            if (key <= lv) begin
              pred  <= li;
              state <= ST_WIN;
            end else if (key >= rv) begin
              pred  <= ri;
              state <= ST_WIN;
            end else begin
              num   <= key - lv;
              den   <= rv - lv;
              state <= ST_MUL;
            end
          end else begin
            if (key >= lv) begin
              pred  <= li;
              state <= ST_WIN;
            end else if (key <= rv) begin
              pred  <= ri;
              state <= ST_WIN;
            end else begin
              num   <= lv - key;
              den   <= lv - rv;
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod    <= prod_next;
          span_sh <= AW'({span_sh, 1'b0});
          if (cnt == '0) begin
            cnt   <= TW'(PW - 1);
            state <= ST_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          q    <= q_next;
          prod <= PW'({prod, 1'b0});
          if (cnt == '0) begin
            pred  <= li + q_next;
            state <= ST_WIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_WIN: begin
          lo    <= LW'(lo_t);
          hi    <= LW'(hi_t);
          state <= ST_LO_RD;
        end
        ST_LO_RD: begin
          state <= ST_LO_CMP;
        end
        ST_LO_CMP: begin
          if ($signed(e_rdata) > key) begin
            lo <= LW'(li);
          end
          state <= ST_HI_CMP;
        end
        ST_HI_CMP: begin
          if ($signed(e_rdata) < key) begin
            hi <= LW'(ri);
          end
          state <= ST_BS_CHECK;
        end
        ST_BS_CHECK: begin
          if (lo <= hi) begin
            bmid  <= AW'(bs_mid);
            state <= ST_BS_CMP;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_BS_CMP: begin
          if ($signed(e_rdata) < key) begin
            lo    <= LW'(bmid) + 1'b1;
            state <= ST_BS_CHECK;
          end else if ($signed(e_rdata) > key) begin
            if (bmid == '0) begin
              state <= ST_DONE;
            end else begin
              hi    <= LW'(bmid) - 1'b1;
              state <= ST_BS_CHECK;
            end
          end else begin
            r_found <= 1'b1;
            r_pos   <= bmid;
            if ((pdist_w > tw) && (32'(anchor_count) < ANCHOR_DEPTH)) begin
              j     <= KW'(anchor_count);
              state <= ST_SH_CHECK;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SH_CHECK: begin
          if (j > apos) begin
            state <= ST_SH_WR;
          end else begin
            anchor_count <= anchor_count + 1'b1;
            r_added      <= 1'b1;
            state        <= ST_DONE;
          end
        end
        ST_SH_WR: begin
          j     <= j - 1'b1;
          state <= ST_SH_CHECK;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            found        <= r_found;
            position     <= POS_W'(r_pos);
            anchor_added <= r_added;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `include "learned_anchor_interpolation_search_assert.svh"

  `LAIS_AST_NOW(a_count_max, 1'b1, 32'(anchor_count) <= ANCHOR_DEPTH, "anchor count overflow")
  `LAIS_AST_NEXT(a_load_clears, load_fire, anchor_count == '0, "load left anchors")
  `LAIS_AST_NOW(a_added_found, out_valid && anchor_added, found, "anchor added on a miss")
  `LAIS_AST_NOW(a_miss_pos, out_valid && !found, position == '0, "miss with nonzero position")

endmodule
